// ===== rtl/assert_macros.svh =====
// Assertion macros used by the back end of the decode/execute unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted.
`define CSDE_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define CSDE_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define CSDE_ASSERT(lbl, ck, rn, prop, msg)
`define CSDE_ASSERT_ALWAYS(lbl, ck, prop, msg)
`endif

`endif

// ===== rtl/cpu_sde_pkg.sv =====
// Shared types and opcode constants of the decode/execute unit.
`default_nettype none
package cpu_sde_pkg;

    typedef enum logic [1:0] {CL_MOV, CL_ALU, CL_JCC, CL_BAD} cls_t;
    typedef enum logic [1:0] {MEM_NONE, MEM_LOAD, MEM_STORE} memop_t;
    typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_CMP} alu_t;

    // Memory write kinds on the result channel
    localparam logic [1:0] MW_NONE = 2'd0;
    localparam logic [1:0] MW_BYTE = 2'd1;
    localparam logic [1:0] MW_WORD = 2'd2;

    // Opcode prefixes
    localparam logic [5:0] OPC_MOV_RM      = 6'b100010;
    localparam logic [3:0] OPC_MOV_IMM_REG = 4'b1011;
    localparam logic [6:0] OPC_MOV_IMM_RM  = 7'b1100011;
    localparam logic [5:0] OPC_ADD_RM      = 6'b000000;
    localparam logic [5:0] OPC_SUB_RM      = 6'b001010;
    localparam logic [5:0] OPC_CMP_RM      = 6'b001110;
    localparam logic [5:0] OPC_GRP_IMM     = 6'b100000;
    localparam logic [6:0] OPC_ADD_ACC     = 7'b0000010;
    localparam logic [6:0] OPC_SUB_ACC     = 7'b0010110;
    localparam logic [6:0] OPC_CMP_ACC     = 7'b0011110;
    localparam logic [3:0] OPC_JCC         = 4'b0111;

    // Full opcodes with special handling
    localparam logic [7:0] OP_JNE     = 8'h75;
    localparam logic [7:0] OP_GRP_W16 = 8'h81;
    localparam logic [7:0] OP_GRP_SX  = 8'h83;

    // Mod-r/m fields
    localparam logic [1:0] MOD_MEM0 = 2'b00;
    localparam logic [1:0] MOD_DISP8 = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REG  = 2'b11;
    localparam logic [2:0] RM_DIRECT = 3'd6;

    // Immediate group selectors
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    // Register numbers
    localparam logic [2:0] REG_AX = 3'd0;
    localparam logic [2:0] REG_BX = 3'd3;
    localparam logic [2:0] REG_BP = 3'd5;
    localparam logic [2:0] REG_SI = 3'd6;
    localparam logic [2:0] REG_DI = 3'd7;

    // Decoded instruction passed from front to back
    typedef struct packed {
        cls_t        cls;
        logic        w;
        alu_t        kind;
        logic [2:0]  dst;
        logic [2:0]  src;
        logic        src_imm;
        logic [15:0] imm;
        memop_t      mem;
        logic [2:0]  base0;
        logic [2:0]  base1;
        logic        use0;
        logic        use1;
        logic [15:0] disp;
        logic        jne;
        logic [2:0]  len;
    } dec_t;

endpackage
`default_nettype wire

// ===== rtl/cpu_sde_req_if.sv =====
// Instruction window channel.
`default_nettype none
interface cpu_sde_req_if;
    logic        valid;
    logic        ready;
    logic [47:0] instr_window;

    modport source (output valid, output instr_window, input ready);
    modport sink (input valid, input instr_window, output ready);
endinterface
`default_nettype wire

// ===== rtl/cpu_sde_rsp_if.sv =====
// Execution result channel.
`default_nettype none
interface cpu_sde_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_ip;
    logic [2:0]  instr_length;
    logic        reg_written;
    logic [2:0]  reg_number;
    logic [15:0] reg_value;
    logic [1:0]  mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic        zero_flag;
    logic        sign_flag;
    logic        unsupported;

    modport source (output valid, output next_ip, output instr_length, output reg_written,
                    output reg_number, output reg_value, output mem_written,
                    output mem_address, output mem_value, output zero_flag,
                    output sign_flag, output unsupported, input ready);
    modport sink (input valid, input next_ip, input instr_length, input reg_written,
                  input reg_number, input reg_value, input mem_written,
                  input mem_address, input mem_value, input zero_flag,
                  input sign_flag, input unsupported, output ready);
endinterface
`default_nettype wire

// ===== rtl/cpu_subset_decode_execute_unit.sv =====
// Top level of the 16-bit subset decode/execute unit.
`default_nettype none
// The front end decodes each instruction window as soon as it transfers and queues it (two
// entries), so new windows are taken while the back end executes or a result waits. The back
// end retires register, immediate and jump instructions after a register file read and an
// execute step; memory forms go on through the address add, the two-step reciprocal
// reduction modulo DATA_BYTES and the single write port of the byte memory, which a word
// store uses once per byte. After reset a clearing pass zeroes the data memory, during which
// no instruction is taken. An unsupported opcode halts the unit until reset; every later
// window reports unsupported.
module cpu_subset_decode_execute_unit #(
    parameter int DATA_BYTES = 65536
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cpu_sde_req_if.sink   req,
    cpu_sde_rsp_if.source rsp
);
    import cpu_sde_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready, clearing;
    dec_t push_data, pop_data;

    cpu_sde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    cpu_sde_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    cpu_sde_back #(
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .clearing (clearing),
        .rsp      (rsp)
    );
endmodule
`default_nettype wire

// ===== rtl/cpu_sde_front.sv =====
// Front end: accepts instruction windows, decodes them and tracks the halt.
`default_nettype none
module cpu_sde_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cpu_sde_req_if.sink        req,
    input  wire logic          clearing,
    output logic               push_valid,
    input  wire logic          push_ready,
    output cpu_sde_pkg::dec_t  push_data
);
    import cpu_sde_pkg::*;

    logic        halted_reg;
    logic [7:0]  b0, b1, b2, b3, b4, b5;
    logic [7:0]  op;
    logic [1:0]  md;
    logic [2:0]  rg, rm;
    logic        direct;
    logic [2:0]  ea_n;
    logic [2:0]  imm_pos;
    logic [15:0] ea_disp;
    logic [15:0] rm_imm;
    dec_t        dec;

    // Split the window into bytes
    assign b0 = req.instr_window[7:0];
    assign b1 = req.instr_window[15:8];
    assign b2 = req.instr_window[23:16];
    assign b3 = req.instr_window[31:24];
    assign b4 = req.instr_window[39:32];
    assign b5 = req.instr_window[47:40];
    assign op = b0;
    assign md = b1[7:6];
    assign rg = b1[5:3];
    assign rm = b1[2:0];
    assign direct = (md == MOD_MEM0) && (rm == RM_DIRECT);

    // Size of the mod-r/m byte plus displacement, and the displacement itself
    always_comb
    begin
        ea_n = 3'd1;
        ea_disp = 16'h0000;
        if (md == MOD_REG)
        begin
            ea_n = 3'd1;
        end
        else if (direct || md == MOD_DISP16)
        begin
            ea_n = 3'd3;
            ea_disp = {b3, b2};
        end
        else if (md == MOD_DISP8)
        begin
            ea_n = 3'd2;
            ea_disp = {{8{b2[7]}}, b2};
        end
    end

    // Immediate after the address bytes of mov immediate to r/m
    assign imm_pos = 3'd1 + ea_n;
    always_comb
    begin
        case (imm_pos)
            3'd2:    rm_imm = {b3, b2};
            3'd3:    rm_imm = {b4, b3};
            default: rm_imm = {b5, b4};
        endcase
    end

    // Classify the instruction
    always_comb
    begin
        dec = '0;
        dec.cls = CL_BAD;
        dec.w = op[0];
        dec.kind = ALU_ADD;
        dec.mem = MEM_NONE;
        dec.disp = ea_disp;
        dec.use0 = !direct;
        dec.use1 = !direct && !rm[2];
        case (rm)
            3'd0:    begin dec.base0 = REG_BX; dec.base1 = REG_SI; end
            3'd1:    begin dec.base0 = REG_BX; dec.base1 = REG_DI; end
            3'd2:    begin dec.base0 = REG_BP; dec.base1 = REG_SI; end
            3'd3:    begin dec.base0 = REG_BP; dec.base1 = REG_DI; end
            3'd4:    begin dec.base0 = REG_SI; dec.base1 = REG_SI; end
            3'd5:    begin dec.base0 = REG_DI; dec.base1 = REG_DI; end
            3'd6:    begin dec.base0 = REG_BP; dec.base1 = REG_BP; end
            default: begin dec.base0 = REG_BX; dec.base1 = REG_BX; end
        endcase

        if (op[7:2] == OPC_MOV_RM)
        begin
            dec.cls = CL_MOV;
            dec.len = 3'd1 + ea_n;
            if (md == MOD_REG)
            begin
                dec.dst = op[1] ? rg : rm;
                dec.src = op[1] ? rm : rg;
            end
            else if (op[1])
            begin
                dec.mem = MEM_LOAD;
                dec.dst = rg;
            end
            else
            begin
                dec.mem = MEM_STORE;
                dec.src = rg;
            end
        end
        else if (op[7:4] == OPC_MOV_IMM_REG)
        begin
            dec.cls = CL_MOV;
            dec.w = op[3];
            dec.dst = op[2:0];
            dec.src_imm = 1'b1;
            dec.imm = {op[3] ? b2 : 8'h00, b1};
            dec.len = op[3] ? 3'd3 : 3'd2;
        end
        else if (op[7:1] == OPC_MOV_IMM_RM)
        begin
            dec.cls = CL_MOV;
            dec.src_imm = 1'b1;
            dec.imm = {op[0] ? rm_imm[15:8] : 8'h00, rm_imm[7:0]};
            dec.len = imm_pos + (op[0] ? 3'd2 : 3'd1);
            dec.dst = rm;
            if (md != MOD_REG)
            begin
                dec.mem = MEM_STORE;
            end
        end
        else if (op[7:2] == OPC_ADD_RM || op[7:2] == OPC_SUB_RM || op[7:2] == OPC_CMP_RM)
        begin
            if (md == MOD_REG)
            begin
                dec.cls = CL_ALU;
                dec.kind = (op[7:2] == OPC_ADD_RM) ? ALU_ADD :
                           ((op[7:2] == OPC_SUB_RM) ? ALU_SUB : ALU_CMP);
                dec.dst = op[1] ? rg : rm;
                dec.src = op[1] ? rm : rg;
                dec.len = 3'd2;
            end
        end
        else if (op[7:2] == OPC_GRP_IMM)
        begin
            if (md == MOD_REG && (rg == GRP_ADD || rg == GRP_SUB || rg == GRP_CMP))
            begin
                dec.cls = CL_ALU;
                dec.kind = (rg == GRP_ADD) ? ALU_ADD : ((rg == GRP_SUB) ? ALU_SUB : ALU_CMP);
                dec.dst = rm;
                dec.src_imm = 1'b1;
                if (op == OP_GRP_W16)
                begin
                    dec.imm = {b3, b2};
                    dec.len = 3'd4;
                end
                else if (op == OP_GRP_SX)
                begin
                    dec.imm = {{8{b2[7]}}, b2};
                    dec.len = 3'd3;
                end
                else
                begin
                    dec.imm = {8'h00, b2};
                    dec.len = 3'd3;
                end
            end
        end
        else if (op[7:1] == OPC_ADD_ACC || op[7:1] == OPC_SUB_ACC || op[7:1] == OPC_CMP_ACC)
        begin
            dec.cls = CL_ALU;
            dec.kind = (op[7:1] == OPC_ADD_ACC) ? ALU_ADD :
                       ((op[7:1] == OPC_SUB_ACC) ? ALU_SUB : ALU_CMP);
            dec.dst = REG_AX;
            dec.src_imm = 1'b1;
            dec.imm = {op[0] ? b2 : 8'h00, b1};
            dec.len = op[0] ? 3'd3 : 3'd2;
        end
        else if (op[7:4] == OPC_JCC)
        begin
            dec.cls = CL_JCC;
            dec.jne = (op == OP_JNE);
            dec.imm = {{8{b1[7]}}, b1};
            dec.len = 3'd2;
        end

        // Once halted, every item answers as unsupported
        if (halted_reg)
        begin
            dec.cls = CL_BAD;
        end
        if (dec.cls == CL_BAD)
        begin
            dec.len = 3'd0;
            dec.mem = MEM_NONE;
        end
    end

    // Hand the decoded item to the queue; hold off during the memory clear
    assign push_valid = req.valid && !clearing;
    assign req.ready = push_ready && !clearing;
    assign push_data = dec;

    // Latch the halt on an unsupported transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_reg <= 1'b0;
        end
        else if (req.valid && req.ready && dec.cls == CL_BAD)
        begin
            halted_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cpu_sde_queue.sv =====
// Two-entry queue of decoded instructions between front and back.
`default_nettype none
module cpu_sde_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire cpu_sde_pkg::dec_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output cpu_sde_pkg::dec_t      pop_data
);
    import cpu_sde_pkg::*;

    localparam int DEPTH = 2;

    dec_t       ent_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign push_ready = (cnt_reg != 2'(DEPTH));
    assign pop_valid = (cnt_reg != 2'd0);
    assign pop_data = ent_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cpu_sde_back.sv =====
// Back end: register file, flags, data memory and the execute sequencer.
`default_nettype none
`include "assert_macros.svh"
module cpu_sde_back #(
    parameter int DATA_BYTES = 65536
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire cpu_sde_pkg::dec_t q_data,
    output logic                   clearing,
    cpu_sde_rsp_if.source          rsp
);
    import cpu_sde_pkg::*;

    localparam int AW = $clog2(DATA_BYTES);
    localparam longint unsigned RECIP = ((64'd1 << 32) + DATA_BYTES - 1) / DATA_BYTES;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
    localparam int PW = 16 + RECIP_W;
    localparam int QW = PW - 32;
    localparam logic [16:0] NUM = 17'(DATA_BYTES);
    localparam logic [AW-1:0] LAST = AW'(DATA_BYTES - 1);

    typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_MOD1, ST_MOD2, ST_MEM, ST_LOAD, ST_STHI}
        state_t;

    typedef struct packed {
        logic [15:0] next_ip;
        logic [2:0]  len;
        logic        rw;
        logic [2:0]  rnum;
        logic [15:0] rval;
        logic [1:0]  mw;
        logic [15:0] maddr;
        logic [15:0] mval;
        logic        zf;
        logic        sf;
        logic        bad;
    } res_t;

    function automatic logic [2:0] phys(input logic w, input logic [2:0] r);
        phys = w ? r : {1'b0, r[1:0]};
    endfunction

    function automatic logic [15:0] bsel(input logic w, input logic [2:0] r,
                                         input logic [15:0] v);
        if (w)
            bsel = v;
        else if (r[2])
            bsel = {8'h00, v[15:8]};
        else
            bsel = {8'h00, v[7:0]};
    endfunction

    function automatic logic [15:0] merge(input logic w, input logic [2:0] r,
                                          input logic [15:0] old, input logic [15:0] v);
        if (w)
            merge = v;
        else if (r[2])
            merge = {v[7:0], old[7:0]};
        else
            merge = {old[15:8], v[7:0]};
    endfunction

    state_t          state_reg;
    dec_t            cur_reg;
    logic [15:0]     gpr_reg [8];
    logic            zf_reg, sf_reg;
    logic [15:0]     ip_reg;
    logic [15:0]     rd0_reg, rd1_reg;
    logic [15:0]     ea_reg;
    logic [PW-1:0]   prod_reg;
    logic [AW-1:0]   addr0_reg, addr1_reg;
    logic [7:0]      mrd0_reg, mrd1_reg;
    logic            clr_busy_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic            out_valid_reg;
    res_t            out_reg;
    logic [7:0]      mem [DATA_BYTES];

    logic            slot_free;
    logic            pop;
    logic [2:0]      ra0, ra1;
    logic [15:0]     op_a, op_b, alu_raw, alu_res, wval, new_full, ld_val, ld_full, st_val;
    logic [15:0]     ea_sum;
    logic [15:0]     ip_next;
    logic [QW-1:0]   quot;
    logic [QW+16:0]  qn, r_full;
    logic [16:0]     rem, rem1;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [7:0]      mem_wd;
    logic            fin_exec, fin_byte_st, fin_hi, fin_ld, finish;
    logic            wr_reg;
    logic [15:0]     wr_val;
    res_t            res;

    assign clearing = clr_busy_reg;
    assign slot_free = !out_valid_reg || rsp.ready;
    assign q_ready = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign pop = q_ready && q_valid;

    // Register file read addresses
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ra0 = (q_data.mem != MEM_NONE) ? q_data.base0 : phys(q_data.w, q_data.dst);
        end
        else
        begin
            ra0 = (cur_reg.mem == MEM_STORE) ? phys(cur_reg.w, cur_reg.src)
                                              : phys(cur_reg.w, cur_reg.dst);
        end
        ra1 = (q_data.mem != MEM_NONE) ? q_data.base1 : phys(q_data.w, q_data.src);
    end

    // Operands, ALU and write-back values
    always_comb
    begin
        op_a = bsel(cur_reg.w, cur_reg.dst, rd0_reg);
        op_b = cur_reg.src_imm ? cur_reg.imm : bsel(cur_reg.w, cur_reg.src, rd1_reg);
        alu_raw = (cur_reg.kind == ALU_ADD) ? op_a + op_b : op_a - op_b;
        alu_res = cur_reg.w ? alu_raw : {8'h00, alu_raw[7:0]};
        wval = (cur_reg.cls == CL_ALU) ? alu_res : op_b;
        new_full = merge(cur_reg.w, cur_reg.dst, rd0_reg, wval);
        ld_val = cur_reg.w ? {mrd1_reg, mrd0_reg} : {8'h00, mrd0_reg};
        ld_full = merge(cur_reg.w, cur_reg.dst, rd0_reg, ld_val);
        st_val = cur_reg.src_imm ? cur_reg.imm : bsel(cur_reg.w, cur_reg.src, rd0_reg);
        if (!cur_reg.w)
        begin
            st_val = {8'h00, st_val[7:0]};
        end
        ea_sum = (cur_reg.use0 ? rd0_reg : 16'h0000) + (cur_reg.use1 ? rd1_reg : 16'h0000)
                 + cur_reg.disp;
    end

    // Next pointer
    always_comb
    begin
        case (cur_reg.cls)
            CL_BAD:  ip_next = ip_reg;
            CL_JCC:  ip_next = ip_reg + 16'(cur_reg.len)
                               + ((cur_reg.jne && !zf_reg) ? cur_reg.imm : 16'h0000);
            default: ip_next = ip_reg + 16'(cur_reg.len);
        endcase
    end

    // Address reduction: quotient by reciprocal, then remainder
    assign quot = prod_reg[PW-1:32];
    assign qn = (QW + 17)'(quot) * (QW + 17)'(NUM);
    assign r_full = (QW + 17)'(ea_reg) - qn;
    assign rem = r_full[16:0];
    assign rem1 = (ea_reg == 16'hFFFF) ? 17'd0 : (((rem + 17'd1) == NUM) ? 17'd0 : rem + 17'd1);

    // Completion conditions
    assign fin_exec = (state_reg == ST_EXEC) && (cur_reg.mem == MEM_NONE) && slot_free;
    assign fin_byte_st = (state_reg == ST_MEM) && (cur_reg.mem == MEM_STORE) && !cur_reg.w
                         && slot_free;
    assign fin_hi = (state_reg == ST_STHI) && slot_free;
    assign fin_ld = (state_reg == ST_LOAD) && slot_free;
    assign finish = fin_exec || fin_byte_st || fin_hi || fin_ld;

    // Register write and result fields
    always_comb
    begin
        wr_reg = 1'b0;
        wr_val = new_full;
        res = '0;
        res.next_ip = ip_next;
        res.len = cur_reg.len;
        res.zf = zf_reg;
        res.sf = sf_reg;
        res.bad = (cur_reg.cls == CL_BAD);
        if (cur_reg.mem == MEM_LOAD)
        begin
            wr_reg = 1'b1;
            wr_val = ld_full;
        end
        else if (cur_reg.mem == MEM_STORE)
        begin
            res.mw = cur_reg.w ? MW_WORD : MW_BYTE;
            res.maddr = ea_reg;
            res.mval = st_val;
        end
        else if (cur_reg.cls == CL_MOV)
        begin
            wr_reg = 1'b1;
        end
        else if (cur_reg.cls == CL_ALU)
        begin
            wr_reg = (cur_reg.kind != ALU_CMP);
            res.zf = (alu_res == 16'h0000);
            res.sf = cur_reg.w ? alu_res[15] : alu_res[7];
        end
        if (wr_reg)
        begin
            res.rw = 1'b1;
            res.rnum = phys(cur_reg.w, cur_reg.dst);
            res.rval = wr_val;
        end
    end

    // Sequencer, architectural state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= 16'h0000;
            end
            zf_reg <= 1'b0;
            sf_reg <= 1'b0;
            ip_reg <= 16'h0000;
            clr_busy_reg <= 1'b1;
            clr_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Sweep the data memory after reset
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end

            // Drop the result once it transfers, unless a new one takes its place
            if (out_valid_reg && rsp.ready && !finish)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (cur_reg.mem != MEM_NONE)
                    begin
                        state_reg <= ST_MOD1;
                    end
                    else if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MOD1: state_reg <= ST_MOD2;
                ST_MOD2: state_reg <= ST_MEM;
                ST_MEM:
                begin
                    if (cur_reg.mem == MEM_LOAD)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else if (cur_reg.w)
                    begin
                        state_reg <= ST_STHI;
                    end
                    else if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase

            // Retire: update state and present the result
            if (finish)
            begin
                if (wr_reg)
                begin
                    gpr_reg[phys(cur_reg.w, cur_reg.dst)] <= wr_val;
                end
                zf_reg <= res.zf;
                sf_reg <= res.sf;
                ip_reg <= ip_next;
                out_valid_reg <= 1'b1;
                out_reg <= res;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
            rd1_reg <= gpr_reg[ra1];
        end
        if (pop || (state_reg == ST_EXEC && cur_reg.mem != MEM_NONE))
        begin
            rd0_reg <= gpr_reg[ra0];
        end
        if (state_reg == ST_EXEC)
        begin
            ea_reg <= ea_sum;
        end
        if (state_reg == ST_MOD1)
        begin
            prod_reg <= PW'(ea_reg) * PW'(RECIP_V);
        end
        if (state_reg == ST_MOD2)
        begin
            addr0_reg <= rem[AW-1:0];
            addr1_reg <= rem1[AW-1:0];
        end
    end

    // Data memory port
    assign mem_we = clr_busy_reg || (state_reg == ST_STHI)
                    || (state_reg == ST_MEM && cur_reg.mem == MEM_STORE);
    assign mem_wa = clr_busy_reg ? clr_cnt_reg : ((state_reg == ST_STHI) ? addr1_reg : addr0_reg);
    assign mem_wd = clr_busy_reg ? 8'h00 : ((state_reg == ST_STHI) ? st_val[15:8] : st_val[7:0]);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mrd0_reg <= mem[addr0_reg];
        mrd1_reg <= mem[addr1_reg];
    end

    // Result channel
    assign rsp.valid = out_valid_reg;
    assign rsp.next_ip = out_reg.next_ip;
    assign rsp.instr_length = out_reg.len;
    assign rsp.reg_written = out_reg.rw;
    assign rsp.reg_number = out_reg.rnum;
    assign rsp.reg_value = out_reg.rval;
    assign rsp.mem_written = out_reg.mw;
    assign rsp.mem_address = out_reg.maddr;
    assign rsp.mem_value = out_reg.mval;
    assign rsp.zero_flag = out_reg.zf;
    assign rsp.sign_flag = out_reg.sf;
    assign rsp.unsupported = out_reg.bad;

    `CSDE_ASSERT(a_no_pop_in_clear, clk, rst_n, q_ready |-> !clr_busy_reg, "pop during memory clear")
    `CSDE_ASSERT(a_addr_in_range, clk, rst_n, (state_reg == ST_MEM) |-> (32'(addr0_reg) < DATA_BYTES), "reduced address out of range")
    `CSDE_ASSERT(a_hi_after_lo, clk, rst_n, (state_reg == ST_STHI) |-> ($past(state_reg) == ST_MEM || $past(state_reg) == ST_STHI), "high byte store without low byte")
    `CSDE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> (state_reg == ST_IDLE && !out_valid_reg), "sequencer not idle in reset")
endmodule
`default_nettype wire
